// ===== src/ssmc_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmc_pkg: shared types and constants of the shifted stack median combine
// Field widths, register indexes and the value reported for uncovered pixels.
// ----------------------------------------------------------------------------
`default_nettype none

package ssmc_pkg;

   // Field widths fixed by the item format
   localparam int POS_W    = 11;
   localparam int SAMPLE_W = 32;
   localparam int SHIFT_W  = 16;
   localparam int COORD_W  = 18;
   localparam int CNT_W    = 4;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int PORT_FRAMES = 8;
   localparam int SHIFTS_PER_REG = 4;

   // Defaults of the top level parameters
   localparam int MAX_FRAMES_DEF = 8;
   localparam int IMAGE_SIZE_DEF = 2048;

   // Result of a pixel that some active frame does not reach (-1.0 in 24.8)
   localparam logic signed [SAMPLE_W-1:0] NOT_COVERED_VALUE = -32'sd256;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SHIFT_W-1:0]  shift_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef logic [CNT_W-1:0]           count_type;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SHIFT_LOW  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SHIFT_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SHIFT_LOW  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SHIFT_HIGH = 3'd4;

endpackage

`default_nettype wire

// ===== src/ssmc_req_if.sv =====
// ----------------------------------------------------------------------------
// ssmc_req_if: request channel of the median combine
// One output pixel position and the sample of every frame at its shift.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssmc_req_if;
   logic                 valid;
   logic                 ready;
   ssmc_pkg::pos_type    pos_x;
   ssmc_pkg::pos_type    pos_y;
   ssmc_pkg::sample_type sample_0;
   ssmc_pkg::sample_type sample_1;
   ssmc_pkg::sample_type sample_2;
   ssmc_pkg::sample_type sample_3;
   ssmc_pkg::sample_type sample_4;
   ssmc_pkg::sample_type sample_5;
   ssmc_pkg::sample_type sample_6;
   ssmc_pkg::sample_type sample_7;

   modport source (output valid, pos_x, pos_y, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, input ready);
   modport sink (input valid, pos_x, pos_y, sample_0, sample_1, sample_2, sample_3,
                 sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

`default_nettype wire

// ===== src/ssmc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ssmc_rsp_if: response channel of the median combine
// Combined pixel value and its coverage flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssmc_rsp_if;
   logic                 valid;
   logic                 ready;
   ssmc_pkg::sample_type combined_value;
   logic                 covered;

   modport source (output valid, combined_value, covered, input ready);
   modport sink (input valid, combined_value, covered, output ready);
endinterface

`default_nettype wire

// ===== src/shifted_stack_median_combine_core.sv =====
// ----------------------------------------------------------------------------
// shifted_stack_median_combine_core: median combine of a shifted frame stack
// Each request item names an output pixel and carries one sample per frame,
// fetched at that frame's shifted position. The response item carries the
// lower median of the active samples, or -1.0 with covered clear when any
// active frame's shifted position falls outside the image.
// Channels: req (valid/ready, position and eight samples), rsp (valid/ready,
// combined value and covered flag). The csr port writes frame count and
// the packed x/y offsets; write it only while no item is in flight.
// Stages: bounds check, pairwise compare, rank select with output register;
// each stage holds its item in a register.
// Throughput: one item per cycle while rsp does not stall; every stage is
// registered and advances when its successor is empty or moving.
// Reset clears all stage valid bits, sets frame count to 1 and offsets to 0.
// When rsp stalls, the output register holds its item and the stages behind
// keep filling until full; req ready then drops, and nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module shifted_stack_median_combine_core #(
   parameter int MAX_FRAMES = ssmc_pkg::MAX_FRAMES_DEF,
   parameter int IMAGE_SIZE = ssmc_pkg::IMAGE_SIZE_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ssmc_req_if.sink                            req,
   ssmc_rsp_if.source                          rsp,
   input  wire logic                           csr_we,
   input  wire logic [ssmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssmc_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   ssmc_pkg::sample_type   port_sample [ssmc_pkg::PORT_FRAMES];
   ssmc_pkg::sample_type   lane_sample [MAX_FRAMES];
   ssmc_pkg::shift_type    dx [MAX_FRAMES];
   ssmc_pkg::shift_type    dy [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  active;
   logic [RANK_W-1:0]      rank_sel;

   logic                   s1_valid, s1_ready, s1_ok;
   ssmc_pkg::sample_type   s1_sample [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  s1_active;
   logic [RANK_W-1:0]      s1_rank_sel;

   logic                   s2_valid, s2_ready, s2_ok;
   ssmc_pkg::sample_type   s2_sample [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  s2_active;
   logic [MAX_FRAMES-1:0]  s2_below [MAX_FRAMES];
   logic [RANK_W-1:0]      s2_rank_sel;

   // Gather the sample ports into lanes
   assign port_sample[0] = req.sample_0;
   assign port_sample[1] = req.sample_1;
   assign port_sample[2] = req.sample_2;
   assign port_sample[3] = req.sample_3;
   assign port_sample[4] = req.sample_4;
   assign port_sample[5] = req.sample_5;
   assign port_sample[6] = req.sample_6;
   assign port_sample[7] = req.sample_7;

   for (genvar f = 0; f < MAX_FRAMES; f++) begin : g_lane
      assign lane_sample[f] = port_sample[f];
   end

   ssmc_csr #(
      .MAX_FRAMES (MAX_FRAMES),
      .RANK_W     (RANK_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .dx        (dx),
      .dy        (dy),
      .active    (active),
      .rank_sel  (rank_sel)
   );

   ssmc_cover #(
      .MAX_FRAMES (MAX_FRAMES),
      .IMAGE_SIZE (IMAGE_SIZE),
      .RANK_W     (RANK_W)
   ) u_cover (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req.valid),
      .in_ready     (req.ready),
      .pos_x        (req.pos_x),
      .pos_y        (req.pos_y),
      .sample       (lane_sample),
      .dx           (dx),
      .dy           (dy),
      .active       (active),
      .rank_sel     (rank_sel),
      .out_valid    (s1_valid),
      .out_ready    (s1_ready),
      .out_sample   (s1_sample),
      .out_active   (s1_active),
      .out_rank_sel (s1_rank_sel),
      .out_ok       (s1_ok)
   );

   ssmc_rank #(
      .MAX_FRAMES (MAX_FRAMES),
      .RANK_W     (RANK_W)
   ) u_rank (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid),
      .in_ready     (s1_ready),
      .in_sample    (s1_sample),
      .in_active    (s1_active),
      .in_rank_sel  (s1_rank_sel),
      .in_ok        (s1_ok),
      .out_valid    (s2_valid),
      .out_ready    (s2_ready),
      .out_sample   (s2_sample),
      .out_active   (s2_active),
      .out_below    (s2_below),
      .out_rank_sel (s2_rank_sel),
      .out_ok       (s2_ok)
   );

   ssmc_select #(
      .MAX_FRAMES (MAX_FRAMES),
      .RANK_W     (RANK_W)
   ) u_select (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid),
      .in_ready    (s2_ready),
      .in_sample   (s2_sample),
      .in_active   (s2_active),
      .in_below    (s2_below),
      .in_rank_sel (s2_rank_sel),
      .in_ok       (s2_ok),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .out_value   (rsp.combined_value),
      .out_covered (rsp.covered)
   );

endmodule

`default_nettype wire

// ===== src/ssmc_csr.sv =====
// ----------------------------------------------------------------------------
// ssmc_csr: configuration registers
// Holds frame count and frame offsets; decodes active lanes and median rank.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmc_csr #(
   parameter int MAX_FRAMES = ssmc_pkg::MAX_FRAMES_DEF,
   parameter int RANK_W     = 3
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [ssmc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssmc_pkg::CSR_W-1:0]      csr_wdata,
   output ssmc_pkg::shift_type                  dx [MAX_FRAMES],
   output ssmc_pkg::shift_type                  dy [MAX_FRAMES],
   output logic [MAX_FRAMES-1:0]                active,
   output logic [RANK_W-1:0]                    rank_sel
);

   localparam int SW = ssmc_pkg::SHIFT_W;
   localparam int PR = ssmc_pkg::SHIFTS_PER_REG;

   ssmc_pkg::count_type               frame_count_ff, frame_count_in;
   logic [ssmc_pkg::CSR_W-1:0]        x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic [ssmc_pkg::CSR_W-1:0]        y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   ssmc_pkg::count_type               n_act;

   // Decode register writes
   always_comb begin
      frame_count_in = frame_count_ff;
      x_lo_in = x_lo_ff;
      x_hi_in = x_hi_ff;
      y_lo_in = y_lo_ff;
      y_hi_in = y_hi_ff;
      if (csr_we) begin
         case (csr_index)
            ssmc_pkg::CSR_FRAME_COUNT:  frame_count_in = csr_wdata[ssmc_pkg::CNT_W-1:0];
            ssmc_pkg::CSR_X_SHIFT_LOW:  x_lo_in = csr_wdata;
            ssmc_pkg::CSR_X_SHIFT_HIGH: x_hi_in = csr_wdata;
            ssmc_pkg::CSR_Y_SHIFT_LOW:  y_lo_in = csr_wdata;
            ssmc_pkg::CSR_Y_SHIFT_HIGH: y_hi_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= ssmc_pkg::CNT_W'(1);
         x_lo_ff <= '0;
         x_hi_ff <= '0;
         y_lo_ff <= '0;
         y_hi_ff <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         x_lo_ff <= x_lo_in;
         x_hi_ff <= x_hi_in;
         y_lo_ff <= y_lo_in;
         y_hi_ff <= y_hi_in;
      end
   end

   // Clamp frame count to 1..MAX_FRAMES and pick the lower median rank
   always_comb begin
      if (frame_count_ff == '0) begin
         n_act = ssmc_pkg::CNT_W'(1);
      end else if (frame_count_ff > ssmc_pkg::CNT_W'(MAX_FRAMES)) begin
         n_act = ssmc_pkg::CNT_W'(MAX_FRAMES);
      end else begin
         n_act = frame_count_ff;
      end
      rank_sel = RANK_W'((n_act - ssmc_pkg::CNT_W'(1)) >> 1);
   end

   // Slice the per-frame offsets out of the packed registers
   for (genvar f = 0; f < MAX_FRAMES; f++) begin : g_lane
      if (f < PR) begin : g_lo
         assign dx[f] = x_lo_ff[SW*f +: SW];
         assign dy[f] = y_lo_ff[SW*f +: SW];
      end else begin : g_hi
         assign dx[f] = x_hi_ff[SW*(f-PR) +: SW];
         assign dy[f] = y_hi_ff[SW*(f-PR) +: SW];
      end
      assign active[f] = (ssmc_pkg::CNT_W'(f) < n_act);
   end

endmodule

`default_nettype wire

// ===== src/ssmc_cover.sv =====
// ----------------------------------------------------------------------------
// ssmc_cover: coverage stage
// Checks each active frame's shifted position against the image bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmc_cover #(
   parameter int MAX_FRAMES = ssmc_pkg::MAX_FRAMES_DEF,
   parameter int IMAGE_SIZE = ssmc_pkg::IMAGE_SIZE_DEF,
   parameter int RANK_W     = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ssmc_pkg::pos_type    pos_x,
   input  wire ssmc_pkg::pos_type    pos_y,
   input  wire ssmc_pkg::sample_type sample [MAX_FRAMES],
   input  wire ssmc_pkg::shift_type  dx [MAX_FRAMES],
   input  wire ssmc_pkg::shift_type  dy [MAX_FRAMES],
   input  wire logic [MAX_FRAMES-1:0] active,
   input  wire logic [RANK_W-1:0] rank_sel,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ssmc_pkg::sample_type   out_sample [MAX_FRAMES],
   output logic [MAX_FRAMES-1:0]  out_active,
   output logic [RANK_W-1:0]      out_rank_sel,
   output logic                   out_ok
);

   localparam int CW = ssmc_pkg::COORD_W;
   localparam int SW = ssmc_pkg::SHIFT_W;
   localparam logic signed [CW-1:0] IMG_LIM = CW'(IMAGE_SIZE);

   logic                   valid_ff, valid_in;
   ssmc_pkg::sample_type   sample_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  active_ff;
   logic [RANK_W-1:0]      rank_sel_ff;
   logic                   ok_ff, ok_in;
   logic signed [CW-1:0]   px, py;
   logic [MAX_FRAMES-1:0]  miss;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign px = $signed({{(CW-ssmc_pkg::POS_W){1'b0}}, pos_x});
   assign py = $signed({{(CW-ssmc_pkg::POS_W){1'b0}}, pos_y});

   // Flag lanes whose shifted position leaves the image
   for (genvar f = 0; f < MAX_FRAMES; f++) begin : g_lane
      logic signed [CW-1:0] sx, sy;
      assign sx = px + $signed({{(CW-SW){dx[f][SW-1]}}, dx[f]});
      assign sy = py - $signed({{(CW-SW){dy[f][SW-1]}}, dy[f]});
      assign miss[f] = active[f] &&
                       (sx < $signed(CW'(0)) || sx >= IMG_LIM ||
                        sy < $signed(CW'(0)) || sy >= IMG_LIM);
   end

   assign ok_in = (px < IMG_LIM) && (py < IMG_LIM) && (miss == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sample_ff   <= sample;
         active_ff   <= active;
         rank_sel_ff <= rank_sel;
         ok_ff       <= ok_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_sample   = sample_ff;
   assign out_active   = active_ff;
   assign out_rank_sel = rank_sel_ff;
   assign out_ok       = ok_ff;

endmodule

`default_nettype wire

// ===== src/ssmc_rank.sv =====
// ----------------------------------------------------------------------------
// ssmc_rank: compare stage
// Builds the pairwise order matrix of the active samples, ties by lane.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmc_rank #(
   parameter int MAX_FRAMES = ssmc_pkg::MAX_FRAMES_DEF,
   parameter int RANK_W     = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ssmc_pkg::sample_type in_sample [MAX_FRAMES],
   input  wire logic [MAX_FRAMES-1:0] in_active,
   input  wire logic [RANK_W-1:0] in_rank_sel,
   input  wire logic              in_ok,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ssmc_pkg::sample_type   out_sample [MAX_FRAMES],
   output logic [MAX_FRAMES-1:0]  out_active,
   output logic [MAX_FRAMES-1:0]  out_below [MAX_FRAMES],
   output logic [RANK_W-1:0]      out_rank_sel,
   output logic                   out_ok
);

   logic                   valid_ff, valid_in;
   ssmc_pkg::sample_type   sample_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  active_ff;
   logic [MAX_FRAMES-1:0]  below_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  below_in [MAX_FRAMES];
   logic [RANK_W-1:0]      rank_sel_ff;
   logic                   ok_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // below[i][j]: active lane j sorts ahead of lane i
   for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_row
      for (genvar j = 0; j < MAX_FRAMES; j++) begin : g_col
         if (j < i) begin : g_lo
            assign below_in[i][j] = in_active[j] && (in_sample[j] <= in_sample[i]);
         end else if (j > i) begin : g_hi
            assign below_in[i][j] = in_active[j] && (in_sample[j] < in_sample[i]);
         end else begin : g_diag
            assign below_in[i][j] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sample_ff   <= in_sample;
         active_ff   <= in_active;
         below_ff    <= below_in;
         rank_sel_ff <= in_rank_sel;
         ok_ff       <= in_ok;
      end
   end

   assign out_valid    = valid_ff;
   assign out_sample   = sample_ff;
   assign out_active   = active_ff;
   assign out_below    = below_ff;
   assign out_rank_sel = rank_sel_ff;
   assign out_ok       = ok_ff;

endmodule

`default_nettype wire

// ===== src/ssmc_select.sv =====
// ----------------------------------------------------------------------------
// ssmc_select: select stage and output register
// Counts each lane's rank and drives the lane at the median rank.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmc_select #(
   parameter int MAX_FRAMES = ssmc_pkg::MAX_FRAMES_DEF,
   parameter int RANK_W     = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire ssmc_pkg::sample_type in_sample [MAX_FRAMES],
   input  wire logic [MAX_FRAMES-1:0] in_active,
   input  wire logic [MAX_FRAMES-1:0] in_below [MAX_FRAMES],
   input  wire logic [RANK_W-1:0] in_rank_sel,
   input  wire logic              in_ok,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ssmc_pkg::sample_type   out_value,
   output logic                   out_covered
);

   logic                   valid_ff, valid_in;
   ssmc_pkg::sample_type   value_ff, value_in;
   logic                   covered_ff;
   logic [RANK_W-1:0]      rank [MAX_FRAMES];
   logic [MAX_FRAMES-1:0]  hit;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Rank of each lane is the count of lanes sorting ahead of it
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         rank[i] = '0;
         for (int j = 0; j < MAX_FRAMES; j++) begin
            rank[i] = rank[i] + RANK_W'(in_below[i][j]);
         end
         hit[i] = in_active[i] && (rank[i] == in_rank_sel);
      end
   end

   // Exactly one active lane holds the selected rank
   always_comb begin
      value_in = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         value_in = value_in | (hit[i] ? in_sample[i] : '0);
      end
      if (!in_ok) begin
         value_in = ssmc_pkg::NOT_COVERED_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load result on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         value_ff   <= value_in;
         covered_ff <= in_ok;
      end
   end

   assign out_valid   = valid_ff;
   assign out_value   = value_ff;
   assign out_covered = covered_ff;

endmodule

`default_nettype wire
